>>> hw/rtl/efwa_pkg.sv
package efwa_pkg;

    localparam int DEF_MAX_WORKERS = 16;
    localparam int DEF_TIME_BITS   = 48;

    // fixed field widths
    localparam int DUR_W     = 32;
    localparam int CFG_W     = 5;
    localparam int IDX_OUT_W = 4;
    localparam int START_W   = 48;

    // microprogram step counter
    typedef logic [1:0] t_step;

    localparam t_step STEP_WAIT   = 2'd0;
    localparam t_step STEP_FIRST  = 2'd1;
    localparam t_step STEP_SCAN   = 2'd2;
    localparam t_step STEP_UPDATE = 2'd3;

    // datapath operation selected by the control word
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_FIRST,
        OP_SCAN,
        OP_UPDATE
    } t_op;

    // jump condition
    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_START,
        COND_MORE,
        COND_ALWAYS
    } t_cond;

    typedef struct packed {
        logic  busy;
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // status fed back from the datapath to the sequencer
    typedef struct packed {
        logic start;
        logic more;
    } t_status;

    // control store
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            STEP_WAIT:   w = '{busy: 1'b0, op: OP_LOAD,   cond: COND_NO_START, target: STEP_WAIT};
            STEP_FIRST:  w = '{busy: 1'b1, op: OP_FIRST,  cond: COND_NONE,     target: STEP_WAIT};
            STEP_SCAN:   w = '{busy: 1'b1, op: OP_SCAN,   cond: COND_MORE,     target: STEP_SCAN};
            STEP_UPDATE: w = '{busy: 1'b1, op: OP_UPDATE, cond: COND_ALWAYS,   target: STEP_WAIT};
            default:     w = '{busy: 1'b0, op: OP_LOAD,   cond: COND_NONE,     target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/efwa_ram.sv
module efwa_ram import efwa_pkg::*; #(
    parameter int WIDTH = DEF_TIME_BITS,
    parameter int DEPTH = DEF_MAX_WORKERS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/efwa_seq.sv
module efwa_seq import efwa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uword  o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_jump;

    assign w_word = ucode(r_step);

    always_comb begin
        unique case (w_word.cond)
            COND_NONE:     w_jump = 1'b0;
            COND_NO_START: w_jump = !i_status.start;
            COND_MORE:     w_jump = i_status.more;
            COND_ALWAYS:   w_jump = 1'b1;
            default:       w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_word.target : t_step'(r_step + 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = w_word;

`ifndef SYNTH
    a_wait_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_WAIT && !i_status.start) |=> r_step == STEP_WAIT)
        else $error("sequencer left wait without a start");
    a_update_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == STEP_UPDATE |=> r_step == STEP_WAIT)
        else $error("update step not followed by wait");
    a_first_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == STEP_FIRST |=> r_step == STEP_SCAN)
        else $error("first read not followed by scan");
`endif

endmodule

>>> hw/rtl/earliest_free_worker_assign.sv
// Earliest-free-worker job assignment. Each job transfer (i_start high while o_busy is low)
// carries a duration; the block scans the free times of the active workers, picks the one
// that is free earliest (lower index wins a tie), reports that worker and its start time,
// and advances the worker's free time by the duration, clipping at the all-ones value and
// flagging the clip. The scan covers the effective active worker count (1 to MAX_WORKERS):
// after the job is taken, the workers are read in order through the free-time table's single
// read port and compared, the winner's free time is written back, and the result appears
// on the cycle after that, strobed by o_valid for exactly one cycle.
// The receiver cannot stall; o_busy drops in the cycle the result is shown, so the next job
// may be transferred then. Free times read as zero after reset with no clearing pass.
// active_workers is written through i_cfg_we; the user must write it only while idle, as the
// block does not enforce it. Zero counts as one and values above MAX_WORKERS are clipped.
module earliest_free_worker_assign import efwa_pkg::*; #(
    parameter int MAX_WORKERS = DEF_MAX_WORKERS,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // job command
    input  logic                 i_start,
    input  logic [DUR_W-1:0]     i_duration,
    output logic                 o_busy,
    // result
    output logic                 o_valid,
    output logic [IDX_OUT_W-1:0] o_worker_index,
    output logic [START_W-1:0]   o_start_time,
    output logic                 o_time_saturated,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // sequencer
    t_uword  w_ctrl;
    t_status w_status;

    // configuration and control state
    logic [CFG_W-1:0]       r_active;
    logic [MAX_WORKERS-1:0] r_valid;     // entry written since reset
    logic                   r_first;     // next compare is the first of the scan
    logic                   r_out_valid;

    // datapath registers
    logic [DUR_W-1:0]       r_dur;
    logic [CNT_W-1:0]       r_ptr;       // next worker to read
    logic [IDX_W-1:0]       r_cmp_idx;   // worker whose data is on the ram output
    logic                   r_rd_valid;
    logic [IDX_W-1:0]       r_best_idx;
    logic [TIME_BITS-1:0]   r_best_time;
    logic [IDX_OUT_W-1:0]   r_out_idx;
    logic [START_W-1:0]     r_out_start;
    logic                   r_out_sat;

    logic [CMP_W-1:0]       w_eff;
    logic                   w_more;
    logic                   w_rd_en;
    logic [IDX_W-1:0]       w_rd_idx;
    logic [TIME_BITS-1:0]   w_ram_q;
    logic [TIME_BITS-1:0]   w_cur_time;
    logic                   w_take;
    logic [TIME_BITS:0]     w_sum_full;
    logic [TIME_BITS-1:0]   w_sum;
    logic                   w_sat;
    logic                   w_wr_en;

    efwa_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    efwa_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_WORKERS)
    ) u_free_time (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (r_best_idx),
        .i_wdata (w_sum),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_idx),
        .o_rdata (w_ram_q)
    );

    // effective worker count: zero means one, clipped at the table depth
    always_comb begin
        priority if (r_active == '0) begin
            w_eff = CMP_W'(1);
        end else if (CMP_W'(r_active) > CMP_W'(MAX_WORKERS)) begin
            w_eff = CMP_W'(MAX_WORKERS);
        end else begin
            w_eff = CMP_W'(r_active);
        end
    end

    assign w_more          = CMP_W'(r_ptr) < w_eff;
    assign w_status.start  = i_start;
    assign w_status.more   = w_more;

    // reads go to the workers in order, in the first step and in scan steps while more remain
    assign w_rd_idx = r_ptr[IDX_W-1:0];
    assign w_rd_en  = (w_ctrl.op == OP_FIRST) || (w_ctrl.op == OP_SCAN && w_more);

    // entries never written since reset read as zero
    assign w_cur_time = r_rd_valid ? w_ram_q : '0;
    // strictly smaller replaces the best so far, keeping the lower index on a tie
    assign w_take     = r_first || (w_cur_time < r_best_time);

    // free time update with saturation at the all-ones value
    assign w_sum_full = (TIME_BITS + 1)'(r_best_time) + (TIME_BITS + 1)'(r_dur);
    assign w_sat      = w_sum_full[TIME_BITS];
    assign w_sum      = w_sat ? '1 : w_sum_full[TIME_BITS-1:0];
    assign w_wr_en    = (w_ctrl.op == OP_UPDATE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= CFG_W'(1);
            r_valid     <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            r_out_valid <= w_wr_en;
            if (w_wr_en) begin
                r_valid[r_best_idx] <= 1'b1;
            end
            unique case (w_ctrl.op)
                OP_FIRST:  r_first <= 1'b1;
                OP_SCAN:   r_first <= 1'b0;
                OP_LOAD,
                OP_UPDATE: r_first <= r_first;
                default:   r_first <= r_first;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_valid <= r_valid[w_rd_idx];
            r_cmp_idx  <= w_rd_idx;
            r_ptr      <= r_ptr + CNT_W'(1);
        end
        unique case (w_ctrl.op)
            OP_LOAD: begin
                if (i_start) begin
                    r_dur <= i_duration;
                    r_ptr <= '0;
                end
            end
            OP_SCAN: begin
                if (w_take) begin
                    r_best_time <= w_cur_time;
                    r_best_idx  <= r_cmp_idx;
                end
            end
            OP_UPDATE: begin
                r_out_idx   <= IDX_OUT_W'(r_best_idx);
                r_out_start <= START_W'(r_best_time);
                r_out_sat   <= w_sat;
            end
            OP_FIRST: begin
            end
            default: begin
            end
        endcase
    end

    assign o_busy           = w_ctrl.busy;
    assign o_valid          = r_out_valid;
    assign o_worker_index   = r_out_idx;
    assign o_start_time     = r_out_start;
    assign o_time_saturated = r_out_sat;

`ifndef SYNTH
    a_strobe_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_ctrl.op == OP_UPDATE))
        else $error("result strobe without an update step");
    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("job transfer did not start the sequencer");
    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_UPDATE) |-> (CMP_W'(r_best_idx) < w_eff))
        else $error("chosen worker outside the active set");
    a_no_strobe_while_scanning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_SCAN) |-> !o_valid)
        else $error("result strobe during a scan");
`endif

endmodule

>>> tb/earliest_free_worker_assign_test.sv
module earliest_free_worker_assign_test;
    import efwa_pkg::*;

    // block configuration as built here
    localparam int MAX_WORKERS = DEF_MAX_WORKERS;
    localparam int TIME_W      = DEF_TIME_BITS;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // the settle time covers one job in flight
    localparam int SETTLE_CYCLES = MAX_WORKERS + 4;
    localparam int DRAIN_CYCLES  = MAX_WORKERS + 8;
    localparam int RANDOM_JOBS   = 1800;

    // what one entry of the command queue asks the driver to do
    typedef enum logic {
        CMD_JOB,
        CMD_SET_WORKERS
    } t_cmd_kind;

    typedef struct {
        t_cmd_kind   kind;
        logic [31:0] value;
        int unsigned gap;
    } t_command;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] worker_index;
        logic [START_W-1:0]   start_time;
        logic                 time_saturated;
    } t_assignment;

    // clock, reset and block inputs, all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    logic [DUR_W-1:0]     i_duration  = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    logic                 o_busy;
    logic                 o_valid;
    logic [IDX_OUT_W-1:0] o_worker_index;
    logic [START_W-1:0]   o_start_time;
    logic                 o_time_saturated;

    // commands still to be driven, and assignments still to come back
    t_command    command_queue[$];
    t_assignment expected_assignments[$];

    // private copy of the scheduler state
    logic [TIME_W-1:0] model_free_time [MAX_WORKERS];
    logic [CFG_W-1:0]  model_active_cfg;

    // set at the rising edge when a job transfer took place
    logic        job_taken = 1'b0;
    int unsigned gap_left;
    int unsigned idle_count;

    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned saturated_seen;
    int unsigned cfg_writes;

    always #4 i_clk = ~i_clk;

    earliest_free_worker_assign uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_duration       (i_duration),
        .o_busy           (o_busy),
        .o_valid          (o_valid),
        .o_worker_index   (o_worker_index),
        .o_start_time     (o_start_time),
        .o_time_saturated (o_time_saturated),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // pick the earliest free worker among the active ones, report it, and
    // push its free time on by the duration with clipping at the top
    function automatic t_assignment assign_earliest_worker(input logic [DUR_W-1:0] dur);
        int unsigned       n;
        int unsigned       best;
        logic [TIME_W:0]   sum;
        t_assignment       res;
        // zero counts as one worker, anything past the table is clipped
        if (model_active_cfg == 0)
            n = 1;
        else if (model_active_cfg > MAX_WORKERS)
            n = MAX_WORKERS;
        else
            n = 32'(model_active_cfg);
        best = 0;
        // strictly smaller only, so a tie keeps the lower index
        for (int unsigned w = 1; w < n; w++) begin
            if (model_free_time[w] < model_free_time[best])
                best = w;
        end
        res.worker_index   = IDX_OUT_W'(best);
        res.start_time     = START_W'(model_free_time[best]);
        sum                = {1'b0, model_free_time[best]} + (TIME_W + 1)'(dur);
        res.time_saturated = (sum > {1'b0, TIME_MAX});
        model_free_time[best] = res.time_saturated ? TIME_MAX : sum[TIME_W-1:0];
        return res;
    endfunction

    // idle time between transfers: mostly none or short, now and then long
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(24, 1);
        return $urandom_range(100, 40);
    endfunction

    function automatic void push_job(input logic [31:0] dur, input int unsigned gap);
        t_command c;
        c.kind  = CMD_JOB;
        c.value = dur;
        c.gap   = gap;
        command_queue.push_back(c);
    endfunction

    function automatic void push_worker_count(input int unsigned count);
        t_command c;
        c.kind  = CMD_SET_WORKERS;
        c.value = count;
        c.gap   = 0;
        command_queue.push_back(c);
    endfunction

    // driver: everything changes on the falling edge
    always @(negedge i_clk) begin : drive_proc
        logic     start_nxt;
        logic     we_nxt;
        t_command head;
        start_nxt = 1'b0;
        we_nxt    = 1'b0;
        // count quiet cycles so that a register write only lands on an idle block
        if (expected_assignments.size() == 0 && o_busy === 1'b0 && !i_start)
            idle_count++;
        else
            idle_count = 0;
        if (!i_rst_n) begin
            gap_left = 0;
        end else if (i_start && !job_taken) begin
            // job still waiting for its transfer, hold it
            start_nxt = 1'b1;
        end else if (gap_left != 0) begin
            gap_left--;
        end else if (command_queue.size() != 0) begin
            head = command_queue[0];
            if (head.kind == CMD_JOB) begin
                void'(command_queue.pop_front());
                start_nxt  = 1'b1;
                i_duration <= head.value[DUR_W-1:0];
                gap_left   = head.gap;
            end else if (idle_count >= SETTLE_CYCLES) begin
                void'(command_queue.pop_front());
                we_nxt      = 1'b1;
                i_cfg_wdata <= head.value[CFG_W-1:0];
            end
        end
        i_start  <= start_nxt;
        i_cfg_we <= we_nxt;
    end

    // monitor: sample on the rising edge, check results, then predict new jobs
    always @(posedge i_clk) begin : check_proc
        t_assignment want;
        if (!i_rst_n) begin
            job_taken <= 1'b0;
            model_active_cfg = CFG_W'(1);
            for (int w = 0; w < MAX_WORKERS; w++)
                model_free_time[w] = '0;
            expected_assignments.delete();
        end else begin
            job_taken <= (i_start && o_busy === 1'b0);
            // a result may share its cycle with the next job transfer, so check first
            if (o_valid === 1'b1) begin
                if (expected_assignments.size() == 0) begin
                    $error("result with no job outstanding: worker %0d start %0d",
                           o_worker_index, o_start_time);
                    mismatches++;
                end else begin
                    want = expected_assignments.pop_front();
                    if (o_worker_index !== want.worker_index) begin
                        $error("worker_index: expected %0d, got %0d",
                               want.worker_index, o_worker_index);
                        mismatches++;
                    end
                    if (o_start_time !== want.start_time) begin
                        $error("start_time: expected %0d, got %0d",
                               want.start_time, o_start_time);
                        mismatches++;
                    end
                    if (o_time_saturated !== want.time_saturated) begin
                        $error("time_saturated: expected %0b, got %0b",
                               want.time_saturated, o_time_saturated);
                        mismatches++;
                    end
                    results_checked++;
                    if (want.time_saturated)
                        saturated_seen++;
                end
            end
            if (i_start && o_busy === 1'b0)
                expected_assignments.push_back(assign_earliest_worker(i_duration));
            if (i_cfg_we) begin
                model_active_cfg = i_cfg_wdata;
                cfg_writes++;
            end
        end
    end

    // command list, reset, and the wait for the end of the run
    initial begin : stimulus_proc
        int unsigned jobs_left;
        int unsigned seg_len;
        int unsigned roll;
        int unsigned count;
        logic [31:0] dur;
        bit          no_idle;

        // directed: single worker with the extremes of the duration
        push_job(32'h0000_0000, idle_gap());
        push_job(32'hFFFF_FFFF, idle_gap());
        push_job(32'h0000_0001, idle_gap());
        push_job(32'hAAAA_AAAA, idle_gap());
        push_job(32'h5555_5555, idle_gap());
        // zero active workers behaves as one
        push_worker_count(0);
        push_job(32'd5, idle_gap());
        // idle workers tie at zero, lowest index wins
        push_worker_count(4);
        push_job(32'd0, 0);
        push_job(32'd0, 0);
        push_job(32'd3, idle_gap());
        push_job(32'd3, idle_gap());
        // full table, then a count beyond it that should clip
        push_worker_count(MAX_WORKERS);
        for (int k = 0; k < 4; k++)
            push_job(32'h100, idle_gap());
        push_worker_count(31);
        for (int k = 0; k < 3; k++)
            push_job(32'h7, idle_gap());
        // shrink and grow again: left-out workers keep their free times
        push_worker_count(2);
        push_job(32'h1000, idle_gap());
        push_job(32'h1000, idle_gap());
        push_worker_count(MAX_WORKERS);
        push_job(32'h20, idle_gap());
        push_job(32'h20, idle_gap());

        // random: segments of jobs, each behind a fresh worker count
        jobs_left = RANDOM_JOBS;
        while (jobs_left > 0) begin
            roll = $urandom_range(9);
            case (roll)
                0: count = 0;
                1: count = 1;
                2: count = MAX_WORKERS;
                3: count = 31;
                4: count = $urandom_range(30, MAX_WORKERS + 1);
                default: count = $urandom_range(MAX_WORKERS, 2);
            endcase
            push_worker_count(count);
            no_idle = ($urandom_range(3) == 0);
            seg_len = $urandom_range(220, 80);
            for (int k = 0; k < seg_len && jobs_left > 0; k++) begin
                roll = $urandom_range(99);
                // short and zero durations make plenty of ties
                if (roll < 10)
                    dur = 32'd0;
                else if (roll < 35)
                    dur = $urandom_range(7);
                else if (roll < 42)
                    dur = 32'hFFFF_FFFF - $urandom_range(3);
                else if (roll < 52)
                    dur = 32'd1 << $urandom_range(31);
                else
                    dur = $urandom();
                push_job(dur, no_idle ? 0 : idle_gap());
                jobs_left--;
            end
        end

        // wind down: worker 0 alone with a long and a zero-length job,
        // then bring the others back in
        push_worker_count(1);
        push_job(32'hFFFF_FFFF, 0);
        push_job(32'd0, idle_gap());
        push_worker_count(17);
        for (int k = 0; k < 3; k++)
            push_job($urandom(), idle_gap());

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all commands driven and every transfer answered
        do
            @(negedge i_clk);
        while (command_queue.size() != 0 || i_start || expected_assignments.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_assignments.size() != 0) begin
            $error("%0d assignments never came back", expected_assignments.size());
            mismatches++;
        end

        $display("run covered %0d job results over %0d worker count writes", results_checked,
                 cfg_writes);
        $display("%0d results had a clipped free time", saturated_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin : timeout_proc
        #16_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
